// ===== sv/sorted_list_with_stats_defines.svh =====
// assertion macros shared by the sorted list block
// no dependencies; included by files that carry concurrent checks
`ifndef SORTED_LIST_WITH_STATS_DEFINES_SVH
`define SORTED_LIST_WITH_STATS_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define SLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");
// next-cycle implication, disabled while reset is low
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");
`else
`define SLS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/sls_pkg.sv =====
// shared types and constants of the sorted list block
// no dependencies; used by the channel interfaces, sls_div, the top module and the testbench
package sls_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 8;
    localparam int COUNT_W_DEF  = $clog2(CAPACITY_DEF + 1);

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_RD,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== sv/sls_if.sv =====
// request and result channels of the sorted list block
// depends on sls_pkg
interface sls_in_if;
    import sls_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [VALUE_W-1:0]  value;
    logic        [INDEX_W-1:0]  index;

    modport source (output valid, func, value, index, input ready);
    modport sink   (input valid, func, value, index, output ready);
endinterface

interface sls_out_if #(
    parameter int CNT_W = sls_pkg::COUNT_W_DEF
);
    import sls_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [CNT_W-1:0]    count;
    logic signed [VALUE_W-1:0]  min_value;
    logic signed [VALUE_W-1:0]  max_value;
    logic signed [VALUE_W-1:0]  mean_value;
    logic signed [VALUE_W-1:0]  element;
    logic        [1:0]          status;

    modport source (output valid, count, min_value, max_value, mean_value, element, status,
                    input ready);
    modport sink   (input valid, count, min_value, max_value, mean_value, element, status,
                    output ready);
endinterface

// ===== sv/sls_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/sls_div.sv =====
// radix-2 restoring divider: signed sum by unsigned count, truncated toward zero
// depends on sls_pkg
module sls_div #(
    parameter int SUM_W = 41,
    parameter int CNT_W = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [SUM_W-1:0]           i_dividend,
    input  logic        [CNT_W-1:0]           i_divisor,
    output logic                              o_done,
    output logic signed [sls_pkg::VALUE_W-1:0] o_quotient
);
    import sls_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_div, n_div;
    logic              r_neg, n_neg;

    logic [SUM_W-1:0]  mag;
    logic [CNT_W:0]    sh;
    logic [CNT_W:0]    diff;
    logic              fits;
    logic [SUM_W-1:0]  q_full;

    assign mag  = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
    assign sh   = {r_rem, r_quo[SUM_W-1]};
    assign fits = sh >= {1'b0, r_div};
    assign diff = sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(SUM_W);
            n_rem  = '0;
            n_quo  = mag;
            n_div  = i_divisor;
            n_neg  = i_dividend[SUM_W-1];
        end else if (r_busy) begin
            // one quotient bit per cycle, msb first
            n_rem  = fits ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
            n_quo  = {r_quo[SUM_W-2:0], fits};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    // sign of the quotient follows the dividend
    assign q_full     = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_done     = r_done;
    assign o_quotient = q_full[VALUE_W-1:0];
endmodule

// ===== sv/sorted_list_with_stats.sv =====
// sorted list of signed q16.16 values with count, min, max and mean
// depends on sls_pkg, sls_if, sls_ram, sls_div and sorted_list_with_stats_defines.svh
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  i_req    | in  | valid / ready | func, value, index
//  o_rsp    | out | valid / ready | count, min_value, max_value, mean_value,
//           |     |               | element, status
//
// insert: shifts each larger entry up one place (up to count entries), overlapped with
//   the divider for the mean, and ends when both the shifts and the divider are done;
//   the single write port of the value ram sets the shift rate
// read: one ram read; a dropped insert or a bad index goes straight to the result
// reset clears count, sum and all control; the value ram needs no clearing pass
// a new request is taken as soon as the previous result sits in the output
//   register, even while the sink stalls it
`include "sorted_list_with_stats_defines.svh"
module sorted_list_with_stats #(
    parameter int CAPACITY = sls_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sls_in_if.sink    i_req,
    sls_out_if.source o_rsp
);
    import sls_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = VALUE_W + AW + 1;
    localparam int CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    // control state
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic                      r_div_start, n_div_start;
    logic                      r_mean_ok, n_mean_ok;
    logic                      r_out_valid;

    // working payload
    logic signed [VALUE_W-1:0] r_min, n_min;
    logic signed [VALUE_W-1:0] r_max, n_max;
    logic signed [VALUE_W-1:0] r_mean, n_mean;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic signed [VALUE_W-1:0] r_element, n_element;
    logic [AW-1:0]             r_pos, n_pos;
    t_status                   r_status, n_status;

    // output register
    logic [CNT_W-1:0]          r_o_count;
    logic signed [VALUE_W-1:0] r_o_min, r_o_max, r_o_mean, r_o_element;
    t_status                   r_o_status;

    // value ram port
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [VALUE_W-1:0]        ram_wdata, ram_rdata;

    // divider
    logic                      div_done;
    logic signed [VALUE_W-1:0] div_quotient;

    logic                      in_acc;
    logic                      out_free;
    logic                      out_load;
    logic                      full;
    logic                      in_range;
    logic                      greater;
    logic [CMP_W-1:0]          idx_ext, cnt_ext;

    assign in_acc   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign out_load = (r_state == S_DONE) && out_free;
    assign full     = r_count == CNT_W'(CAPACITY);
    assign idx_ext  = CMP_W'(i_req.index);
    assign cnt_ext  = CMP_W'(r_count);
    assign in_range = idx_ext < cnt_ext;
    // entry just read is above the new value, so it moves up one place
    assign greater  = $signed(ram_rdata) > r_value;

    assign i_req.ready = r_state == S_IDLE;

    sls_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sls_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req.func == FUNC_READ) begin
                        n_state = in_range ? S_RD : S_DONE;
                    end else if (full) begin
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!greater) begin
                    n_state = S_DIV;
                end else if (r_pos == AW'(1)) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: n_state = S_DIV;
            S_RD:    n_state = S_DONE;
            S_DIV: begin
                if (r_mean_ok) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_mean      = r_mean;
        n_value     = r_value;
        n_element   = r_element;
        n_pos       = r_pos;
        n_status    = r_status;
        n_div_start = 1'b0;
        n_mean_ok   = r_mean_ok;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_value;
        ram_re      = 1'b0;
        ram_raddr   = r_pos - AW'(1);

        // mean lands whenever the divider finishes, possibly mid-scan
        if (div_done) begin
            n_mean    = div_quotient;
            n_mean_ok = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_value   = i_req.value;
                    n_element = '0;
                    n_status  = ST_OK;
                    if (i_req.func == FUNC_READ) begin
                        if (in_range) begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(idx_ext);
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        // count, sum, min and max are settled now; the scan only moves entries
                        n_count     = r_count + CNT_W'(1);
                        n_sum       = r_sum + SUM_W'(i_req.value);
                        n_div_start = 1'b1;
                        n_mean_ok   = 1'b0;
                        n_pos       = AW'(r_count);
                        if (r_count == '0) begin
                            n_min     = i_req.value;
                            n_max     = i_req.value;
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = i_req.value;
                        end else begin
                            n_min     = (i_req.value < r_min) ? i_req.value : r_min;
                            n_max     = (i_req.value > r_max) ? i_req.value : r_max;
                            ram_re    = 1'b1;
                            ram_raddr = AW'(r_count - CNT_W'(1));
                        end
                    end
                end
            end
            S_SCAN: begin
                // ram_rdata holds entry r_pos-1; write and next read never collide
                ram_we = 1'b1;
                if (greater) begin
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - AW'(1);
                    if (r_pos != AW'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_pos - AW'(1) - AW'(1);
                    end
                end else begin
                    ram_wdata = r_value;
                end
            end
            S_PLACE: begin
                // every held entry was larger, new value goes to the bottom
                ram_we    = 1'b1;
                ram_wdata = r_value;
            end
            S_RD: begin
                n_element = ram_rdata;
            end
            S_DIV, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_div_start <= 1'b0;
            r_mean_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_div_start <= n_div_start;
            r_mean_ok   <= n_mean_ok;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min     <= n_min;
        r_max     <= n_max;
        r_mean    <= n_mean;
        r_value   <= n_value;
        r_element <= n_element;
        r_pos     <= n_pos;
        r_status  <= n_status;
        if (out_load) begin
            // an empty list reports zero statistics
            r_o_count   <= r_count;
            r_o_min     <= (r_count == '0) ? '0 : r_min;
            r_o_max     <= (r_count == '0) ? '0 : r_max;
            r_o_mean    <= (r_count == '0) ? '0 : r_mean;
            r_o_element <= r_element;
            r_o_status  <= r_status;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.count      = r_o_count;
    assign o_rsp.min_value  = r_o_min;
    assign o_rsp.max_value  = r_o_max;
    assign o_rsp.mean_value = r_o_mean;
    assign o_rsp.element    = r_o_element;
    assign o_rsp.status     = r_o_status;

    // checks
    `SLS_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    `SLS_ASSERT_IMPL(a_scan_below_count, i_clk, i_rst_n,
                     r_state == S_SCAN, CNT_W'(r_pos) < r_count)
    `SLS_ASSERT_IMPL(a_min_not_above_max, i_clk, i_rst_n, r_count != '0, r_min <= r_max)
    `SLS_ASSERT_IMPL(a_full_drop_at_capacity, i_clk, i_rst_n,
                     o_rsp.valid && (o_rsp.status == ST_FULL), o_rsp.count == CNT_W'(CAPACITY))
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench of the sorted list block: directed table then random requests,
// every result checked field by field against the list predictor or a typed row's own result
// depends on sls_pkg, sls_if and sorted_list_with_stats
module tb_top;
    import sls_pkg::*;

    localparam int LIST_CAP   = CAPACITY_DEF;
    localparam int DIR_N      = 25;
    localparam int RAND_N     = 1500;
    localparam int STALL_MAX  = 5000;  // cycles with no handshake on either side
    localparam int DRAIN_WAIT = 300;   // longer than the longest insert: full shift with the divider overlapped
    localparam int HOLD_LONG  = 600;   // receiver hold-off, well past one insert

    typedef struct packed {
        t_func                      func;
        logic signed [VALUE_W-1:0]  value;
        logic        [INDEX_W-1:0]  index;
    } list_req_t;

    typedef struct packed {
        logic        [8:0]          count;
        logic signed [VALUE_W-1:0]  min_value;
        logic signed [VALUE_W-1:0]  max_value;
        logic signed [VALUE_W-1:0]  mean_value;
        logic signed [VALUE_W-1:0]  element;
        t_status                    status;
    } list_stats_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        list_req_t   req;
        logic        typed;
        list_stats_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    sls_in_if  req_if ();
    sls_out_if rsp_if ();

    sorted_list_with_stats #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predictor state: ascending copy of the list, count and exact sum
    logic signed [VALUE_W-1:0] sorted_vals [0:LIST_CAP-1];
    int                        held_n;
    longint                    held_sum;

    list_stats_t stats_due [$];   // results owed by the block, oldest first
    list_stats_t due_head;
    dir_row_t    dir_tab [0:DIR_N-1];

    int mismatches;
    int results_seen;
    int idle_cycles;
    int hold_left;     // receiver hold-off, counted down by the receiver itself
    bit steady;        // no random idling on either side while set; the long hold-off still applies

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // insert at the sorted place (after equal values) or read one entry,
    // then report count, min, max and the mean truncated toward zero
    function automatic list_stats_t apply_list_request(input list_req_t r);
        list_stats_t s;
        int          pos;
        longint      quo;
        begin
            s = '0;
            if (r.func == FUNC_INSERT) begin
                if (held_n >= LIST_CAP) begin
                    s.status = ST_FULL;
                end else begin
                    pos = held_n;
                    while (pos > 0 && $signed(sorted_vals[pos-1]) > $signed(r.value)) begin
                        sorted_vals[pos] = sorted_vals[pos-1];
                        pos--;
                    end
                    sorted_vals[pos] = r.value;
                    held_n++;
                    held_sum += $signed(r.value);
                end
            end else if (int'(r.index) < held_n) begin
                s.element = sorted_vals[r.index];
            end else begin
                s.status = ST_RANGE;
            end
            s.count = held_n[8:0];
            if (held_n > 0) begin
                s.min_value  = sorted_vals[0];
                s.max_value  = sorted_vals[held_n-1];
                quo          = held_sum / longint'(held_n);
                s.mean_value = quo[31:0];
            end
            return s;
        end
    endfunction

    function automatic dir_row_t mk_row(input t_func f, input logic [31:0] v,
                                        input logic [7:0] ix, input logic typed,
                                        input logic [8:0] c, input logic [31:0] mn,
                                        input logic [31:0] mx, input logic [31:0] mean,
                                        input logic [31:0] el, input t_status st);
        dir_row_t row;
        begin
            row.req.func        = f;
            row.req.value       = v;
            row.req.index       = ix;
            row.typed           = typed;
            row.want.count      = c;
            row.want.min_value  = mn;
            row.want.max_value  = mx;
            row.want.mean_value = mean;
            row.want.element    = el;
            row.want.status     = st;
            return row;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("%0t result %0d %s: got %h, expected %h",
                     $time, results_seen, what, got, want);
            mismatches++;
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_request(input list_req_t r, input logic typed,
                                 input list_stats_t typed_want);
        list_stats_t pred;
        begin
            if (!steady && $urandom_range(99) < 15) begin
                req_if.valid = 1'b0;
                repeat ($urandom_range(4, 1)) @(negedge clk);
            end
            req_if.valid = 1'b1;
            req_if.func  = r.func;
            req_if.value = r.value;
            req_if.index = r.index;
            do @(posedge clk); while (!req_if.ready);
            // predictor always advances; typed rows override its result
            pred = apply_list_request(r);
            stats_due.push_back(typed ? typed_want : pred);
            @(negedge clk);
        end
    endtask

    // receiver: random stalls, quiet stretches, and the long hold-off
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else if (steady) begin
                rsp_if.ready = 1'b1;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= 15);
            end
        end
    end

    // result checker: each accepted result against the oldest one owed
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (stats_due.size() == 0) begin
                report_mismatch("unexpected result, count", 32'(rsp_if.count), 32'd0);
            end else begin
                due_head = stats_due.pop_front();
                if (rsp_if.count !== due_head.count)
                    report_mismatch("count", 32'(rsp_if.count), 32'(due_head.count));
                if (rsp_if.min_value !== due_head.min_value)
                    report_mismatch("min_value", rsp_if.min_value, due_head.min_value);
                if (rsp_if.max_value !== due_head.max_value)
                    report_mismatch("max_value", rsp_if.max_value, due_head.max_value);
                if (rsp_if.mean_value !== due_head.mean_value)
                    report_mismatch("mean_value", rsp_if.mean_value, due_head.mean_value);
                if (rsp_if.element !== due_head.element)
                    report_mismatch("element", rsp_if.element, due_head.element);
                if (rsp_if.status !== due_head.status)
                    report_mismatch("status", 32'(rsp_if.status), 32'(due_head.status));
            end
            results_seen++;
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge clk) begin
        if (rst_n && !(req_if.valid && req_if.ready) && !(rsp_if.valid && rsp_if.ready))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        list_req_t r;
        int        i;
        int        n;

        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FUNC_INSERT;
        req_if.value  = '0;
        req_if.index  = '0;
        held_n        = 0;
        held_sum      = 0;
        mismatches    = 0;
        results_seen  = 0;
        idle_cycles   = 0;
        hold_left     = 0;
        steady        = 1'b0;

        // directed table: empty list, both extremes, reads in and out of range,
        // equal values, negative mean truncation, all-ones and alternating bits
        dir_tab[0]  = mk_row(FUNC_READ,   32'h0000_0000, 8'd0,   1'b1, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_RANGE);
        dir_tab[1]  = mk_row(FUNC_INSERT, 32'h7FFF_FFFF, 8'd0,   1'b1, 9'd1,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, ST_OK);
        dir_tab[2]  = mk_row(FUNC_INSERT, 32'h8000_0000, 8'hFF,  1'b1, 9'd2,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, ST_OK);
        dir_tab[3]  = mk_row(FUNC_READ,   32'hFFFF_FFFF, 8'd0,   1'b1, 9'd2,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, ST_OK);
        dir_tab[4]  = mk_row(FUNC_READ,   32'h0000_0000, 8'd1,   1'b1, 9'd2,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, ST_OK);
        dir_tab[5]  = mk_row(FUNC_READ,   32'h0000_0000, 8'd2,   1'b1, 9'd2,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, ST_RANGE);
        dir_tab[6]  = mk_row(FUNC_READ,   32'h0000_0000, 8'hFF,  1'b1, 9'd2,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, ST_RANGE);
        dir_tab[7]  = mk_row(FUNC_INSERT, 32'h0000_0000, 8'd0,   1'b1, 9'd3,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, ST_OK);
        dir_tab[8]  = mk_row(FUNC_INSERT, 32'h0000_0000, 8'd0,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[9]  = mk_row(FUNC_INSERT, 32'h0001_0000, 8'd0,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[10] = mk_row(FUNC_INSERT, 32'hFFFF_0000, 8'd0,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[11] = mk_row(FUNC_INSERT, 32'h8000_0000, 8'd0,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[12] = mk_row(FUNC_INSERT, 32'h7FFF_FFFF, 8'd0,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[13] = mk_row(FUNC_INSERT, 32'h5555_5555, 8'hAA,  1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[14] = mk_row(FUNC_INSERT, 32'hAAAA_AAAA, 8'h55,  1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[15] = mk_row(FUNC_READ,   32'h0000_0000, 8'd0,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[16] = mk_row(FUNC_READ,   32'h0000_0000, 8'd4,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[17] = mk_row(FUNC_READ,   32'h0000_0000, 8'd9,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[18] = mk_row(FUNC_READ,   32'h0000_0000, 8'd10,  1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[19] = mk_row(FUNC_READ,   32'h0000_0000, 8'hAA,  1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[20] = mk_row(FUNC_READ,   32'h0000_0000, 8'h55,  1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[21] = mk_row(FUNC_INSERT, 32'hFFFF_FFFF, 8'd0,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[22] = mk_row(FUNC_READ,   32'h0000_0000, 8'hFF,  1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[23] = mk_row(FUNC_READ,   32'h0000_0000, 8'd5,   1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);
        dir_tab[24] = mk_row(FUNC_READ,   32'h0000_0000, 8'd10,  1'b0, 9'd0,
                             32'h0, 32'h0, 32'h0, 32'h0, ST_OK);

        // synchronous reset, released at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_N; i++)
            offer_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

        // random part: about a third inserts, so the list fills part way through
        // and the rest of the run exercises dropped inserts and full-list reads
        for (n = 0; n < RAND_N; n++) begin
            steady = (n >= 200 && n < 300) || (n >= 900 && n < 1100);
            // receiver holds off while the sender keeps pushing: block backs up
            if (n == 220)
                hold_left = HOLD_LONG;
            // sender pauses until the block has handed back every result
            if (n == 700) begin
                req_if.valid = 1'b0;
                wait (stats_due.size() == 0);
                @(negedge clk);
            end
            r.func = ($urandom_range(99) < 35) ? FUNC_INSERT : FUNC_READ;
            case ($urandom_range(9))
                0, 1, 2, 3, 4: r.value = $urandom();
                // narrow band around zero: many equal values, sign changes
                5, 6:          r.value = $urandom_range(32'h0006_0000) - 32'h0003_0000;
                7: begin
                    case ($urandom_range(3))
                        0:       r.value = 32'h8000_0000;
                        1:       r.value = 32'h7FFF_FFFF;
                        2:       r.value = 32'h0000_0000;
                        default: r.value = 32'hFFFF_FFFF;
                    endcase
                end
                default:       r.value = $urandom_range(32'h00FF_FFFF);
            endcase
            // reads mostly land inside the list, some anywhere in the index range
            if (held_n > 0 && $urandom_range(99) < 85)
                r.index = INDEX_W'($urandom_range(held_n - 1));
            else
                r.index = INDEX_W'($urandom_range(255));
            offer_request(r, 1'b0, '0);
        end
        steady       = 1'b0;
        req_if.valid = 1'b0;

        // drain, then give a stray late result time to show up
        wait (stats_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sls_pkg.sv
sv/sls_if.sv
sv/sls_ram.sv
sv/sls_div.sv
sv/sorted_list_with_stats.sv
sim/tb_top.sv
